@@ src/stfd_pkg.sv @@
// Shared types, constants and helper functions for the stuffed trainer frame decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package stfd_pkg;

  localparam int unsigned LineLengthDef = 32;
  localparam int unsigned PacketSize    = 14;
  localparam int unsigned ChanCount     = 8;
  localparam int unsigned ChanW         = 13;
  localparam int unsigned DiscLen       = 11;
  localparam int unsigned HistDepth     = DiscLen + 1;
  localparam int unsigned CfgIdxW       = 2;
  localparam int unsigned CfgDataW      = 8;

  localparam logic [7:0]         SyncByte    = 8'h80;
  localparam logic [7:0]         NewlineByte = 8'h0A;
  localparam logic [ChanW-1:0]   ChanOffset  = 13'd1500;
  localparam logic [8*DiscLen-1:0] DiscText  = "isConnected";

  localparam logic [7:0] DelimRst  = 8'd126;
  localparam logic [7:0] EscapeRst = 8'd125;
  localparam logic [7:0] MaskRst   = 8'd32;

  typedef enum logic [CfgIdxW-1:0] {
    CfgDelim  = 2'd0,
    CfgEscape = 2'd1,
    CfgMask   = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ModeIdle    = 4'b0001,
    ModeStart   = 4'b0010,
    ModeInFrame = 4'b0100,
    ModeEscaped = 4'b1000
  } mode_e;

  typedef struct packed {
    logic [7:0] delim;
    logic [7:0] escape;
    logic [7:0] mask;
  } cfg_t;

  // deframer state as seen by the checker stage
  typedef struct packed {
    logic [PacketSize-1:0][7:0] head;
    logic                       full;
    logic                       disc;
  } step_t;

  function automatic logic checksum_ok(logic [PacketSize-1:0][7:0] h);
    logic [7:0] x;
    x = h[0];
    for (int k = 1; k < PacketSize - 1; k++) begin
      x = x ^ h[k];
    end
    return (x == h[PacketSize-1]) && (h[0] == SyncByte);
  endfunction

  function automatic logic [ChanCount*ChanW-1:0] unpack_chans(
    logic [PacketSize-1:0][7:0] h
  );
    logic [11:0]                ev;
    logic [11:0]                od;
    logic [ChanCount*ChanW-1:0] r;
    r = '0;
    for (int p = 0; p < ChanCount / 2; p++) begin
      ev = {h[2+3*p][7:4], h[1+3*p]};
      od = {h[3+3*p][3:0], h[2+3*p][3:0], h[3+3*p][7:4]};
      r[2*p*ChanW +: ChanW]     = {1'b0, ev} - ChanOffset;
      r[(2*p+1)*ChanW +: ChanW] = {1'b0, od} - ChanOffset;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/stfd_deframer.sv @@
// Deframer: delimiter/escape state machine, byte count, frame head and line history.
// Depends on stfd_pkg.
`default_nettype none

module stfd_deframer #(
  parameter int unsigned LineLength = stfd_pkg::LineLengthDef
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire stfd_pkg::cfg_t cfg_i,
  input  wire logic           accept_i,
  input  wire logic [7:0]     byte_i,
  output stfd_pkg::step_t     step_o
);
  import stfd_pkg::*;

  localparam int unsigned CntW = $clog2(LineLength + 1);

  mode_e                      mode_q, mode_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic                       full_q, full_d;
  logic                       disc_q, disc_d;
  logic [PacketSize-1:0][7:0] head_q, head_d;
  logic [HistDepth-1:0][7:0]  hist_q, hist_d;

  logic       clear, do_store, wr, match;
  logic [7:0] data;

  always_comb begin
    mode_d   = mode_q;
    clear    = 1'b0;
    do_store = 1'b0;
    data     = byte_i;
    case (mode_q)
      ModeStart: begin
        if (byte_i == cfg_i.delim) begin
          mode_d = ModeInFrame;
          clear  = 1'b1;
        end else begin
          do_store = 1'b1;
        end
      end
      ModeInFrame: begin
        if (byte_i == cfg_i.escape) begin
          mode_d = ModeEscaped;
        end else if (byte_i == cfg_i.delim) begin
          clear = 1'b1;
        end else begin
          do_store = 1'b1;
        end
      end
      ModeEscaped: begin
        data     = byte_i ^ cfg_i.mask;
        do_store = 1'b1;
        mode_d   = ModeInFrame;
      end
      default: begin
        if (byte_i == cfg_i.delim) begin
          clear  = 1'b1;
          mode_d = ModeStart;
        end else begin
          do_store = 1'b1;
        end
      end
    endcase

    wr = do_store && (cnt_q < CntW'(LineLength));

    // text match on the bytes before the one preceding the newline
    match = 1'b1;
    for (int i = 0; i < DiscLen; i++) begin
      if (hist_q[DiscLen-i] != DiscText[8*(DiscLen-1-i) +: 8]) begin
        match = 1'b0;
      end
    end
    disc_d = wr && (data == NewlineByte) && (cnt_q >= CntW'(HistDepth)) && match;

    if (clear || disc_d) begin
      cnt_d = '0;
    end else if (wr) begin
      cnt_d = cnt_q + CntW'(1);
    end else begin
      cnt_d = cnt_q;
    end

    full_d = (cnt_d >= CntW'(PacketSize));
    if (full_d) begin
      mode_d = ModeIdle;
    end

    head_d = head_q;
    for (int k = 0; k < PacketSize; k++) begin
      if (wr && (cnt_q == CntW'(k))) begin
        head_d[k] = data;
      end
    end

    hist_d = wr ? {hist_q[HistDepth-2:0], data} : hist_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
      cnt_q  <= '0;
      full_q <= 1'b0;
      disc_q <= 1'b0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      full_q <= full_d;
      disc_q <= disc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      head_q <= head_d;
      hist_q <= hist_d;
    end
  end

  assign step_o.head = head_q;
  assign step_o.full = full_q;
  assign step_o.disc = disc_q;

endmodule

`default_nettype wire

@@ src/stfd_check.sv @@
// Checker stage: checksum and sync test, channel unpacking, result register.
// Depends on stfd_pkg.
`default_nettype none

module stfd_check (
  input  wire logic                                        clk_i,
  input  wire logic                                        rst_ni,
  input  wire logic                                        accept_i,
  input  wire stfd_pkg::step_t                             step_i,
  output logic                                             ready_o,
  output logic                                             out_valid_o,
  input  wire logic                                        out_ready_i,
  output logic [stfd_pkg::ChanCount*stfd_pkg::ChanW-1:0]   out_chans_o,
  output logic [1:0]                                       out_flags_o
);
  import stfd_pkg::*;

  logic                       pend_q, pend_d;
  logic                       ovalid_q, ovalid_d;
  logic [ChanCount*ChanW-1:0] chans_q;
  logic [1:0]                 flags_q;

  logic good, has_res, out_free, move, load;

  assign good     = step_i.full && checksum_ok(step_i.head);
  assign has_res  = step_i.disc || good;
  assign out_free = !ovalid_q || out_ready_i;
  assign move     = pend_q && (!has_res || out_free);
  assign load     = pend_q && has_res && out_free;
  assign ready_o  = !pend_q || move;

  always_comb begin
    pend_d   = accept_i ? 1'b1 : (move ? 1'b0 : pend_q);
    ovalid_d = load ? 1'b1 : (out_ready_i ? 1'b0 : ovalid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      pend_q   <= pend_d;
      ovalid_q <= ovalid_d;
    end
  end

  // disconnect wins; its channels read zero
  always_ff @(posedge clk_i) begin
    if (load) begin
      flags_q <= {step_i.disc, !step_i.disc};
      chans_q <= step_i.disc ? '0 : unpack_chans(step_i.head);
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_chans_o = chans_q;
  assign out_flags_o = flags_q;

endmodule

`default_nettype wire

@@ src/stuffed_trainer_frame_decoder.sv @@
// Throughput: one byte per cycle; the deframer state register feeds the checker stage,
// which only holds input back while its result waits in the stalled output register.
// Reset: asynchronous active low; deframer idle, count zero, config at defaults.
// Top level of the stuffed trainer frame decoder; depends on stfd_pkg, stfd_deframer,
// stfd_check.
`default_nettype none

module stuffed_trainer_frame_decoder #(
  parameter int unsigned LineLength = stfd_pkg::LineLengthDef
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire logic                                      cfg_we_i,
  input  wire logic [stfd_pkg::CfgIdxW-1:0]              cfg_idx_i,
  input  wire logic [stfd_pkg::CfgDataW-1:0]             cfg_data_i,
  input  wire logic                                      s_axis_tvalid,
  output logic                                           s_axis_tready,
  input  wire logic [7:0]                                s_axis_tdata,   // rx_byte
  output logic                                           m_axis_tvalid,
  input  wire logic                                      m_axis_tready,
  // chan_0 .. chan_7, 13 bits each
  output logic [stfd_pkg::ChanCount*stfd_pkg::ChanW-1:0] m_axis_tdata,
  output logic [1:0]                                     m_axis_tuser    // frame_valid, disconnected
);
  import stfd_pkg::*;

  cfg_t  cfg_q;
  step_t step;
  logic  accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delim  <= DelimRst;
      cfg_q.escape <= EscapeRst;
      cfg_q.mask   <= MaskRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgDelim:  cfg_q.delim  <= cfg_data_i;
        CfgEscape: cfg_q.escape <= cfg_data_i;
        CfgMask:   cfg_q.mask   <= cfg_data_i;
        default:   cfg_q        <= cfg_q;
      endcase
    end
  end

  assign accept = s_axis_tvalid && s_axis_tready;

  stfd_deframer #(
    .LineLength(LineLength)
  ) u_deframer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .accept_i(accept),
    .byte_i  (s_axis_tdata),
    .step_o  (step)
  );

  stfd_check u_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .step_i     (step),
    .ready_o    (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_chans_o(m_axis_tdata),
    .out_flags_o(m_axis_tuser)
  );

endmodule

`default_nettype wire

@@ src/stfd_checker.sv @@
// Port-level assertions for the stuffed trainer frame decoder, bound to the top level.
// Depends on stfd_pkg and stuffed_trainer_frame_decoder.
`default_nettype none

module stfd_checker (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire logic                                      m_axis_tvalid,
  input  wire logic                                      m_axis_tready,
  input  wire logic [stfd_pkg::ChanCount*stfd_pkg::ChanW-1:0] m_axis_tdata,
  input  wire logic [1:0]                                m_axis_tuser
);
  import stfd_pkg::*;

  logic chans_in_range;

  always_comb begin
    chans_in_range = 1'b1;
    for (int c = 0; c < ChanCount; c++) begin
      if (($signed(m_axis_tdata[c*ChanW +: ChanW]) < -13'sd1500) ||
          ($signed(m_axis_tdata[c*ChanW +: ChanW]) > 13'sd2595)) begin
        chans_in_range = 1'b0;
      end
    end
  end

  a_valid_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result request dropped while stalled");

  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $onehot(m_axis_tuser))
    else $error("result must be exactly one of frame or disconnect");

  a_disc_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> (m_axis_tdata == '0))
    else $error("disconnect result carries channel data");

  a_chan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> chans_in_range)
    else $error("channel value outside 12-bit field minus offset");

endmodule

bind stuffed_trainer_frame_decoder stfd_checker u_stfd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);

`default_nettype wire
